// ===== design/moesif_line_coherence_fsm_macros.svh =====
// Assertion macros for the coherence controller back end (moesif_back.sv).
// Synthesis builds define SYNTH, which turns every check into nothing.
`ifndef MOESIF_LINE_COHERENCE_FSM_MACROS_SVH
`define MOESIF_LINE_COHERENCE_FSM_MACROS_SVH
`ifndef SYNTH
`define MOESIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MOESIF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define MOESIF_ASSERT(lbl, prop, msg)
`define MOESIF_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== design/moesif_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package moesif_pkg;

  localparam int unsigned KIND_W            = 3;
  localparam int unsigned LINE_ADDR_W       = 32;
  localparam int unsigned NODE_W            = 4;
  localparam int unsigned STATE_W           = 4;
  localparam int unsigned ADDR_BITS_DEFAULT = 32;
  localparam int unsigned QUEUE_DEPTH       = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 3'd0,
    KIND_STORE = 3'd1,
    KIND_GETS  = 3'd2,
    KIND_GETM  = 3'd3,
    KIND_DATA  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_STORE,
    OP_GETS,
    OP_GETM,
    OP_DATA,
    OP_BAD
  } op_e;

  typedef enum logic [STATE_W-1:0] {
    ST_I  = 4'd0,
    ST_IS = 4'd1,
    ST_IM = 4'd2,
    ST_S  = 4'd3,
    ST_SM = 4'd4,
    ST_E  = 4'd5,
    ST_O  = 4'd6,
    ST_M  = 4'd7,
    ST_F  = 4'd8
  } line_state_e;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_GETS = 2'd1,
    REQ_GETM = 2'd2
  } bus_req_e;

  typedef struct packed {
    op_e               op;
    logic [NODE_W-1:0] src;
    logic              shared;
  } item_t;

  typedef struct packed {
    logic                   data_to_proc;
    logic [1:0]             bus_request;
    logic [1:0]             data_sends;
    logic [NODE_W-1:0]      data_dest_node;
    logic [LINE_ADDR_W-1:0] addr_out;
    logic                   shared_assert;
    logic                   miss;
    logic                   silent_upgrade;
    logic                   protocol_error;
    logic [STATE_W-1:0]     new_state;
  } result_t;

endpackage

`default_nettype wire

// ===== design/moesif_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface moesif_in_if;
  logic                               valid;
  logic                               ready;
  logic [moesif_pkg::KIND_W-1:0]      kind;
  logic [moesif_pkg::LINE_ADDR_W-1:0] line_addr;
  logic [moesif_pkg::NODE_W-1:0]      src_node;
  logic                               shared_in;

  modport source (output valid, output kind, output line_addr, output src_node,
                  output shared_in, input ready);
  modport sink (input valid, input kind, input line_addr, input src_node,
                input shared_in, output ready);
endinterface

`default_nettype wire

// ===== design/moesif_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface moesif_out_if;
  logic                               valid;
  logic                               ready;
  logic                               data_to_proc;
  logic [1:0]                         bus_request;
  logic [1:0]                         data_sends;
  logic [moesif_pkg::NODE_W-1:0]      data_dest_node;
  logic [moesif_pkg::LINE_ADDR_W-1:0] addr_out;
  logic                               shared_assert;
  logic                               miss;
  logic                               silent_upgrade;
  logic                               protocol_error;
  logic [moesif_pkg::STATE_W-1:0]     new_state;

  modport source (output valid, output data_to_proc, output bus_request,
                  output data_sends, output data_dest_node, output addr_out,
                  output shared_assert, output miss, output silent_upgrade,
                  output protocol_error, output new_state, input ready);
  modport sink (input valid, input data_to_proc, input bus_request,
                input data_sends, input data_dest_node, input addr_out,
                input shared_assert, input miss, input silent_upgrade,
                input protocol_error, input new_state, output ready);
endinterface

`default_nettype wire

// ===== design/moesif_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module moesif_front #(
  parameter int unsigned ADDR_BITS = moesif_pkg::ADDR_BITS_DEFAULT
) (
  moesif_in_if.sink                             in_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output moesif_pkg::item_t                     item_o,
  output logic [((ADDR_BITS < 32) ? ADDR_BITS : 32)-1:0] addr_o
);
  import moesif_pkg::*;

  localparam int unsigned AddrKeep = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  op_e op;

  always_comb begin
    case (in_i.kind)
      KIND_LOAD:  op = OP_LOAD;
      KIND_STORE: op = OP_STORE;
      KIND_GETS:  op = OP_GETS;
      KIND_GETM:  op = OP_GETM;
      KIND_DATA:  op = OP_DATA;
      default:    op = OP_BAD;
    endcase
  end

  assign in_i.ready    = !full_i;
  assign push_o        = in_i.valid && !full_i;
  assign item_o.op     = op;
  assign item_o.src    = in_i.src_node;
  assign item_o.shared = in_i.shared_in;
  assign addr_o        = in_i.line_addr[AddrKeep-1:0];

endmodule

`default_nettype wire

// ===== design/moesif_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module moesif_fifo #(
  parameter int unsigned ADDR_KEEP = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  moesif_pkg::item_t     item_i,
  input  logic [ADDR_KEEP-1:0]  addr_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output moesif_pkg::item_t     item_o,
  output logic [ADDR_KEEP-1:0]  addr_o
);
  import moesif_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t                item_mem_q [QUEUE_DEPTH];
  logic [ADDR_KEEP-1:0] addr_mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      item_mem_q[wr_ptr_q] <= item_i;
      addr_mem_q[wr_ptr_q] <= addr_i;
    end
  end

  assign item_o = item_mem_q[rd_ptr_q];
  assign addr_o = addr_mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== design/moesif_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "moesif_line_coherence_fsm_macros.svh"

module moesif_back #(
  parameter int unsigned ADDR_KEEP = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  moesif_pkg::item_t    item_i,
  input  logic [ADDR_KEEP-1:0] addr_i,
  output logic                 pop_o,
  moesif_out_if.source         out_o
);
  import moesif_pkg::*;

  line_state_e       state_q, state_d;
  logic              own_vld_q, own_vld_d;
  logic [NODE_W-1:0] own_node_q, own_node_d;
  logic              fwd_vld_q, fwd_vld_d;
  logic              out_vld_q, out_vld_d;
  result_t           res_q, res_d;

  logic              pop;
  logic              err_c;
  logic              to_proc, assert_sh, miss, silent;
  bus_req_e          req;
  logic [1:0]        sends;
  logic              store;
  logic              sh;

  assign pop   = !empty_i && (!out_vld_q || out_o.ready);
  assign pop_o = pop;

  // Next line state and node marks for the item at the head of the queue.
  always_comb begin
    state_d    = state_q;
    own_vld_d  = own_vld_q;
    own_node_d = own_node_q;
    fwd_vld_d  = fwd_vld_q;
    to_proc    = 1'b0;
    req        = REQ_NONE;
    sends      = 2'd0;
    assert_sh  = 1'b0;
    miss       = 1'b0;
    silent     = 1'b0;
    err_c      = 1'b0;
    store      = (item_i.op == OP_STORE);
    sh         = item_i.shared;
    if (item_i.op inside {OP_LOAD, OP_STORE}) begin
      case (state_q)
        ST_I: begin
          req     = store ? REQ_GETM : REQ_GETS;
          state_d = store ? ST_IM : ST_IS;
          miss    = 1'b1;
        end
        ST_S, ST_F: begin
          if (store) begin
            req     = REQ_GETM;
            state_d = ST_SM;
            miss    = 1'b1;
          end else begin
            to_proc = 1'b1;
          end
        end
        ST_O: begin
          if (store) begin
            own_vld_d  = 1'b1;
            own_node_d = item_i.src;
            req        = REQ_GETM;
            state_d    = ST_SM;
            miss       = 1'b1;
          end else begin
            to_proc = 1'b1;
          end
        end
        ST_E: begin
          to_proc = 1'b1;
          if (store) begin
            state_d = ST_M;
            silent  = 1'b1;
          end
        end
        ST_M: begin
          to_proc = 1'b1;
        end
        default: begin
          err_c = 1'b1;
        end
      endcase
    end else if (item_i.op inside {OP_GETS, OP_GETM, OP_DATA}) begin
      case (state_q)
        ST_I: begin
        end
        ST_IS: begin
          if (item_i.op == OP_DATA) begin
            to_proc = 1'b1;
            state_d = sh ? ST_S : ST_E;
          end
        end
        ST_IM: begin
          if (item_i.op == OP_DATA) begin
            to_proc = 1'b1;
            state_d = ST_M;
          end
        end
        ST_S: begin
          if (item_i.op == OP_GETS) begin
            assert_sh = 1'b1;
          end else if (item_i.op == OP_GETM) begin
            state_d = ST_I;
          end
        end
        ST_SM: begin
          if (item_i.op == OP_GETS) begin
            sends     = {1'b0, fwd_vld_q && !sh} + {1'b0, own_vld_q};
            assert_sh = 1'b1;
          end else if (item_i.op == OP_GETM) begin
            // Only one supplier answers: the shared line is raised by the first.
            if ((fwd_vld_q || own_vld_q) && !sh) begin
              assert_sh = 1'b1;
              sends     = 2'd1;
            end
            if (!own_vld_q || (own_node_q != item_i.src)) begin
              state_d    = ST_IM;
              own_vld_d  = 1'b0;
              own_node_d = '0;
            end
          end else begin
            own_vld_d  = 1'b0;
            own_node_d = '0;
            fwd_vld_d  = 1'b0;
            to_proc    = 1'b1;
            state_d    = ST_M;
          end
        end
        ST_E: begin
          if (item_i.op == OP_GETS) begin
            fwd_vld_d = 1'b1;
            assert_sh = 1'b1;
            sends     = 2'd1;
            state_d   = ST_F;
          end else if (item_i.op == OP_GETM) begin
            assert_sh = 1'b1;
            sends     = 2'd1;
            state_d   = ST_I;
          end
        end
        ST_O, ST_F, ST_M: begin
          if (item_i.op == OP_GETS) begin
            assert_sh = 1'b1;
            sends     = 2'd1;
            if (state_q == ST_M) begin
              state_d = ST_O;
            end
          end else if (item_i.op == OP_GETM) begin
            assert_sh = 1'b1;
            sends     = 2'd1;
            state_d   = ST_I;
          end
        end
        default: begin
          err_c = 1'b1;
        end
      endcase
    end else begin
      err_c = 1'b1;
    end
  end

  // Result word for the item at the head of the queue.
  always_comb begin
    res_d                = '0;
    res_d.protocol_error = err_c;
    res_d.new_state      = state_d;
    if (!err_c) begin
      res_d.data_to_proc   = to_proc;
      res_d.bus_request    = req;
      res_d.data_sends     = sends;
      res_d.data_dest_node = (sends != 2'd0) ? item_i.src : '0;
      res_d.addr_out       = (to_proc || (req != REQ_NONE) || (sends != 2'd0)) ?
                             LINE_ADDR_W'(addr_i) : '0;
      res_d.shared_assert  = assert_sh;
      res_d.miss           = miss;
      res_d.silent_upgrade = silent;
    end
    out_vld_d = pop ? 1'b1 : (out_vld_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_I;
      own_vld_q <= 1'b0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (pop && !err_c) begin
        state_q   <= state_d;
        own_vld_q <= own_vld_d;
        fwd_vld_q <= fwd_vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
      if (!err_c) begin
        own_node_q <= own_node_d;
      end
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.data_to_proc   = res_q.data_to_proc;
  assign out_o.bus_request    = res_q.bus_request;
  assign out_o.data_sends     = res_q.data_sends;
  assign out_o.data_dest_node = res_q.data_dest_node;
  assign out_o.addr_out       = res_q.addr_out;
  assign out_o.shared_assert  = res_q.shared_assert;
  assign out_o.miss           = res_q.miss;
  assign out_o.silent_upgrade = res_q.silent_upgrade;
  assign out_o.protocol_error = res_q.protocol_error;
  assign out_o.new_state      = res_q.new_state;

  `MOESIF_ASSERT(a_err_keeps_state, pop && err_c |=> $stable(state_q), "error changed the line state")
  `MOESIF_ASSERT_NEVER(a_owner_only_in_sm, own_vld_q && (state_q != ST_SM), "owner mark valid outside SM")
  `MOESIF_ASSERT(a_dest_zero_without_sends, out_vld_q && (res_q.data_sends == 2'd0) |-> (res_q.data_dest_node == '0), "destination set without a data transfer")
  `MOESIF_ASSERT(a_silent_upgrade_to_m, out_vld_q && res_q.silent_upgrade |-> (res_q.new_state == ST_M) && (res_q.bus_request == REQ_NONE), "silent upgrade without reaching M")

endmodule

`default_nettype wire

// ===== design/moesif_line_coherence_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Coherence controller for one cache line under a snooping MOESIF protocol. Every input
// transfer (processor load or store, snooped GETS, GETM or DATA) yields exactly one result
// transfer carrying the bus request, data sends, shared-line assertion, statistics flags and
// the new line state; items not allowed in the current state raise protocol_error and leave
// the state untouched. A front end classifies each item into a two-entry queue, and the back
// end runs the combinational state decode and loads an output register. The block takes one
// item per clock while the output is not stalled by out_o.ready; each item passes through the
// queue and then the output register before its result is valid. While a result waits on
// out_o.ready, the queue takes up to two more items and then holds in_i.ready low.
module moesif_line_coherence_fsm #(
  parameter int unsigned ADDR_BITS = moesif_pkg::ADDR_BITS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  moesif_in_if.sink    in_i,
  moesif_out_if.source out_o
);
  import moesif_pkg::*;

  localparam int unsigned AddrKeep = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  logic                push, full, pop, empty;
  item_t               front_item, head_item;
  logic [AddrKeep-1:0] front_addr, head_addr;

  moesif_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item),
    .addr_o (front_addr)
  );

  moesif_fifo #(
    .ADDR_KEEP (AddrKeep)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .addr_i  (front_addr),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item),
    .addr_o  (head_addr)
  );

  moesif_back #(
    .ADDR_KEEP (AddrKeep)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (head_item),
    .addr_i  (head_addr),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
